FILE: src/chc_pkg.sv
// chc_pkg: types, sizes and the bucket remainder step for the chained hash cache
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    localparam int BUCKET_COUNT = 101;
    localparam int ENTRY_COUNT  = 64;
    localparam int HASH_MUL     = 97;

    localparam int KEY_W  = 32;
    localparam int ACT_W  = 16;
    localparam int FRM_W  = 16;
    localparam int PLC_W  = 16;
    localparam int OIDX_W = 6;

    localparam int MIX_W   = KEY_W;
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = MIX_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);

    localparam int B_W    = $clog2(BUCKET_COUNT);
    localparam int E_W    = $clog2(ENTRY_COUNT + 1);
    localparam int EI_W   = $clog2(ENTRY_COUNT);
    localparam int STEP_W = $clog2(ENTRY_COUNT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [B_W-1:0]    t_bkt;
    typedef logic [E_W-1:0]    t_link;
    typedef logic [EI_W-1:0]   t_eidx;
    typedef logic [OIDX_W-1:0] t_oidx;
    typedef logic [MIX_W-1:0]  t_mix;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_CMP,
        BK_INS
    } t_back_state;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [ACT_W-1:0] action;
        logic [FRM_W-1:0] frame;
        logic             place_ok;
        logic [PLC_W-1:0] place;
        t_bkt             bucket;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ACT_W-1:0] action;
        logic [FRM_W-1:0] frame;
        logic [PLC_W-1:0] place;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic             inserted;
        logic             table_full;
        t_oidx            entry_index;
        logic [PLC_W-1:0] stored_place;
        logic             redraw;
        logic             redraw_buffer;
        logic             sample_buffer;
    } t_result;

    // one byte of the remainder, msb first, one compare-subtract per bit
    function automatic t_bkt f_mod_step(input t_bkt rem, input logic [DIGIT_W-1:0] dig);
        logic [B_W:0] r;
        r = {1'b0, rem};
        for (int i = 0; i < DIGIT_W; i++) begin
            r = {r[B_W-1:0], dig[DIGIT_W-1-i]};
            if (r >= (B_W+1)'(BUCKET_COUNT)) begin
                r = r - (B_W+1)'(BUCKET_COUNT);
            end
        end
        return r[B_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/chained_hash_cache_with_free_list_top.sv
// chained_hash_cache_with_free_list_top: top level of the chained hash cache
// depends on chc_pkg, chc_front, chc_queue, chc_back
`timescale 1ns / 1ps
`default_nettype none

// A request word is taken at a clock edge where start is high and busy is low; every
// request gives exactly one result word, shown for a single cycle with o_valid high, and
// the receiver cannot hold it off. The front reduces the mixed key to a bucket one byte
// per cycle and can hold a new word while it reduces the last one; a finished bucket
// waits while the queue is full. The table walker pops a word, reads the bucket head,
// compares the chain entries one by one and, for a load with place_ok that misses,
// inserts an entry from the free list, or reports a full table. The two-word queue
// between front and walker absorbs long walks, after which busy stays high.
module chained_hash_cache_with_free_list_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire logic                      i_op,
    input  wire logic [chc_pkg::KEY_W-1:0]  i_key_handle,
    input  wire logic [chc_pkg::ACT_W-1:0]  i_action,
    input  wire logic [chc_pkg::FRM_W-1:0]  i_frame,
    input  wire logic                      i_place_ok,
    input  wire logic [chc_pkg::PLC_W-1:0]  i_place_handle,
    output logic                           busy,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic                           o_inserted,
    output logic                           o_table_full,
    output logic [chc_pkg::OIDX_W-1:0]     o_entry_index,
    output logic [chc_pkg::PLC_W-1:0]      o_stored_place,
    output logic                           o_redraw,
    output logic                           o_redraw_buffer,
    output logic                           o_sample_buffer
);
    import chc_pkg::*;

    logic     push;
    t_req     f_req;
    logic     q_full;
    logic     q_vld;
    t_req     q_req;
    logic     pop;
    t_result  res;

    chc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (i_op),
        .i_key_handle   (i_key_handle),
        .i_action       (i_action),
        .i_frame        (i_frame),
        .i_place_ok     (i_place_ok),
        .i_place_handle (i_place_handle),
        .o_busy         (busy),
        .o_push         (push),
        .o_req          (f_req),
        .i_full         (q_full)
    );

    chc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    chc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_q_req (q_req),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_hit           = res.hit;
    assign o_inserted      = res.inserted;
    assign o_table_full    = res.table_full;
    assign o_entry_index   = res.entry_index;
    assign o_stored_place  = res.stored_place;
    assign o_redraw        = res.redraw;
    assign o_redraw_buffer = res.redraw_buffer;
    assign o_sample_buffer = res.sample_buffer;

endmodule

`default_nettype wire

FILE: src/chc_front.sv
// chc_front: takes request words, mixes the key and reduces it to a bucket number
// depends on chc_pkg; feeds chc_queue
`timescale 1ns / 1ps
`default_nettype none

module chc_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_op,
    input  wire logic [chc_pkg::KEY_W-1:0] i_key_handle,
    input  wire logic [chc_pkg::ACT_W-1:0] i_action,
    input  wire logic [chc_pkg::FRM_W-1:0] i_frame,
    input  wire logic                     i_place_ok,
    input  wire logic [chc_pkg::PLC_W-1:0] i_place_handle,
    output logic                          o_busy,
    output logic                          o_push,
    output chc_pkg::t_req                 o_req,
    input  wire logic                     i_full
);
    import chc_pkg::*;

    logic              r_a_vld;
    t_req              r_a_req;
    t_mix              r_a_mix;
    logic              r_b_vld;
    t_req              r_b_req;
    t_mix              r_b_mix;
    t_bkt              r_rem;
    logic [CNT_W-1:0]  r_cnt;

    logic              accept;
    logic              b_last;
    logic              b_push;
    logic              b_load;
    t_bkt              rem_n;
    t_bkt              rem_first;
    t_mix              mul;

    assign accept    = i_start && !r_a_vld;
    assign b_last    = (r_cnt == CNT_W'(DIGITS - 1));
    assign b_push    = r_b_vld && b_last && !i_full;
    assign b_load    = r_a_vld && (!r_b_vld || b_push);
    assign rem_n     = f_mod_step(r_rem, r_b_mix[(MIX_W-1) - DIGIT_W*int'(r_cnt) -: DIGIT_W]);
    assign rem_first = f_mod_step('0, r_a_mix[MIX_W-1 -: DIGIT_W]);
    assign mul       = MIX_W'(i_action) * MIX_W'(HASH_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_a_vld <= 1'b1;
            end else if (b_load) begin
                r_a_vld <= 1'b0;
            end
            if (b_load) begin
                r_b_vld <= 1'b1;
            end else if (b_push) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_req.op       <= t_op'(i_op);
            r_a_req.key      <= i_key_handle;
            r_a_req.action   <= i_action;
            r_a_req.frame    <= i_frame;
            r_a_req.place_ok <= i_place_ok;
            r_a_req.place    <= i_place_handle;
            r_a_req.bucket   <= '0;
            r_a_mix          <= MIX_W'(i_key_handle) ^ mul;
        end
        if (b_load) begin
            r_b_req <= r_a_req;
            r_b_mix <= r_a_mix;
            r_rem   <= rem_first;
            r_cnt   <= CNT_W'(1);
        end else if (r_b_vld && !b_last) begin
            r_rem <= rem_n;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_comb begin
        o_req        = r_b_req;
        o_req.bucket = rem_n;
    end

    assign o_busy = r_a_vld;
    assign o_push = b_push;

endmodule

`default_nettype wire

FILE: src/chc_queue.sv
// chc_queue: short request queue between the hashing front and the table walker
// depends on chc_pkg
`timescale 1ns / 1ps
`default_nettype none

module chc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire chc_pkg::t_req i_req,
    output logic               o_full,
    output logic               o_vld,
    output chc_pkg::t_req      o_req,
    input  wire logic          i_pop
);
    import chc_pkg::*;

    t_req             r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QC_W-1:0]  r_cnt;

    logic             wr;
    logic             rd;

    assign wr = i_push && !o_full;
    assign rd = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_req;
        end
    end

    assign o_full = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_req  = r_mem[r_rp];

endmodule

`default_nettype wire

FILE: src/chc_back.sv
// chc_back: bucket heads, link and entry memories, free list and the chain walker
// depends on chc_pkg; pops words from chc_queue
`timescale 1ns / 1ps
`default_nettype none

module chc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_vld,
    input  wire chc_pkg::t_req i_q_req,
    output logic               o_pop,
    output logic               o_valid,
    output chc_pkg::t_result   o_res
);
    import chc_pkg::*;

    localparam t_link NO_ENTRY = E_W'(ENTRY_COUNT);

    t_back_state              r_state, n_state;
    t_req                     r_req, n_req;
    t_link                    r_cur, n_cur;
    t_link                    r_head, n_head;
    logic [STEP_W-1:0]        r_steps, n_steps;
    t_link                    r_free, n_free;
    logic                     r_front_first, n_front;
    t_result                  r_res, n_res;
    logic                     r_res_vld, n_res_vld;

    t_link                    r_head_mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0]  r_head_vld;
    t_link                    r_head_rd;
    logic                     r_head_rv;
    t_link                    r_link_mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0]   r_link_vld;
    t_link                    r_link_rd;
    logic                     r_link_rv;
    t_entry                   r_ent_mem [ENTRY_COUNT];
    t_entry                   r_ent_rd;

    t_bkt                     head_raddr;
    logic                     head_we;
    t_eidx                    link_raddr;
    logic                     link_we;
    t_eidx                    ent_raddr;
    logic                     ent_we;
    t_entry                   ent_wd;
    t_link                    cur_head;
    t_link                    nxt;
    t_link                    free_nxt;
    logic                     match;
    logic                     miss;

    assign cur_head = r_head_rv ? r_head_rd : NO_ENTRY;
    assign nxt      = r_link_rv ? r_link_rd : r_cur + E_W'(1);
    assign free_nxt = r_link_rv ? r_link_rd : r_free + E_W'(1);
    assign match    = (r_ent_rd.key == r_req.key) && (r_ent_rd.action == r_req.action);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_cur      = r_cur;
        n_head     = r_head;
        n_steps    = r_steps;
        n_free     = r_free;
        n_front    = r_front_first;
        n_res      = r_res;
        n_res_vld  = 1'b0;
        o_pop      = 1'b0;
        head_raddr = i_q_req.bucket;
        head_we    = 1'b0;
        link_raddr = t_eidx'(r_cur);
        link_we    = 1'b0;
        ent_raddr  = t_eidx'(r_cur);
        ent_we     = 1'b0;
        ent_wd     = r_ent_rd;
        miss       = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_vld) begin
                    o_pop   = 1'b1;
                    n_req   = i_q_req;
                    n_state = BK_HEAD;
                end
            end
            BK_HEAD: begin
                n_head     = cur_head;
                n_cur      = cur_head;
                n_steps    = STEP_W'(1);
                link_raddr = t_eidx'(cur_head);
                ent_raddr  = t_eidx'(cur_head);
                if (cur_head >= NO_ENTRY) begin
                    miss = 1'b1;
                end else begin
                    n_state = BK_CMP;
                end
            end
            BK_CMP: begin
                if (match) begin
                    n_res              = '0;
                    n_res.hit          = 1'b1;
                    n_res.entry_index  = t_oidx'(r_cur);
                    n_res.stored_place = r_ent_rd.place;
                    if (r_req.op == OP_DRAW && r_ent_rd.frame != r_req.frame) begin
                        n_res.redraw        = 1'b1;
                        n_res.redraw_buffer = !r_front_first;
                        n_front             = !r_front_first;
                        ent_we              = 1'b1;
                        ent_wd.frame        = r_req.frame;
                    end
                    n_res.sample_buffer = !n_front;
                    n_res_vld           = 1'b1;
                    n_state             = BK_IDLE;
                end else if (r_steps == STEP_W'(ENTRY_COUNT) || nxt >= NO_ENTRY) begin
                    miss = 1'b1;
                end else begin
                    n_cur      = nxt;
                    n_steps    = r_steps + STEP_W'(1);
                    link_raddr = t_eidx'(nxt);
                    ent_raddr  = t_eidx'(nxt);
                end
            end
            BK_INS: begin
                head_we      = 1'b1;
                link_we      = 1'b1;
                ent_we       = 1'b1;
                ent_wd.key   = r_req.key;
                ent_wd.action = r_req.action;
                ent_wd.frame = '0;
                ent_wd.place = r_req.place;
                n_free       = free_nxt;
                n_res              = '0;
                n_res.inserted     = 1'b1;
                n_res.entry_index  = t_oidx'(r_free);
                n_res.stored_place = r_req.place;
                n_res.sample_buffer = !r_front_first;
                n_res_vld          = 1'b1;
                n_state            = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (miss) begin
            n_res               = '0;
            n_res.sample_buffer = !r_front_first;
            if (r_req.op == OP_LOAD && r_req.place_ok) begin
                if (r_free >= NO_ENTRY) begin
                    n_res.table_full = 1'b1;
                    n_res_vld        = 1'b1;
                    n_state          = BK_IDLE;
                end else begin
                    link_raddr = t_eidx'(r_free);
                    n_state    = BK_INS;
                end
            end else begin
                n_res_vld = 1'b1;
                n_state   = BK_IDLE;
            end
        end

        if (ent_we && r_state == BK_INS) begin
            ent_raddr = t_eidx'(r_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_free        <= '0;
            r_front_first <= 1'b1;
            r_res_vld     <= 1'b0;
            r_head_vld    <= '0;
            r_link_vld    <= '0;
        end else begin
            r_state       <= n_state;
            r_free        <= n_free;
            r_front_first <= n_front;
            r_res_vld     <= n_res_vld;
            if (head_we) begin
                r_head_vld[r_req.bucket] <= 1'b1;
            end
            if (link_we) begin
                r_link_vld[t_eidx'(r_free)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_cur   <= n_cur;
        r_head  <= n_head;
        r_steps <= n_steps;
        r_res   <= n_res;
    end

    // bucket heads
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[r_req.bucket] <= r_free;
        end
        r_head_rd <= r_head_mem[head_raddr];
        r_head_rv <= r_head_vld[head_raddr];
    end

    // chain and free list links
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[t_eidx'(r_free)] <= r_head;
        end
        r_link_rd <= r_link_mem[link_raddr];
        r_link_rv <= r_link_vld[link_raddr];
    end

    // entry rows
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            if (r_state == BK_INS) begin
                r_ent_mem[t_eidx'(r_free)] <= ent_wd;
            end else begin
                r_ent_mem[t_eidx'(r_cur)] <= ent_wd;
            end
        end
        r_ent_rd <= r_ent_mem[ent_raddr];
    end

    assign o_valid = r_res_vld;
    assign o_res   = r_res;

    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> $past(r_state) != BK_IDLE)
        else $error("result word without a lookup behind it");

    a_hit_xor_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> !(r_res.hit && (r_res.inserted || r_res.table_full)))
        else $error("hit reported together with insert or full");

    a_full_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.table_full) |-> r_free >= NO_ENTRY)
        else $error("table full reported with free entries left");

    a_sample_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> r_res.sample_buffer == !r_front_first)
        else $error("sample buffer disagrees with front flag");

    a_flip_on_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front_first != $past(r_front_first)) |-> (r_res_vld && r_res.redraw))
        else $error("front flag flipped without a redraw");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking bench for chained_hash_cache_with_free_list_top
// a directed table, then random load and draw words, checked by fixed wants or a cache predictor
// depends on chc_pkg and the block's top level
`timescale 1ns / 1ps

module tb_top;
    import chc_pkg::*;

    typedef struct {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [ACT_W-1:0] act;
        logic [FRM_W-1:0] frame;
        logic             ok;
        logic [PLC_W-1:0] place;
        bit               known;
        t_result          want;
    } t_stim_row;

    localparam int RANDOM_WORDS = 2000;
    localparam int POOL_SIZE    = 96;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic i_op = 1'b0;
    logic [KEY_W-1:0] i_key_handle = '0;
    logic [ACT_W-1:0] i_action = '0;
    logic [FRM_W-1:0] i_frame = '0;
    logic i_place_ok = 1'b0;
    logic [PLC_W-1:0] i_place_handle = '0;
    logic busy, o_valid, o_hit, o_inserted, o_table_full;
    logic [OIDX_W-1:0] o_entry_index;
    logic [PLC_W-1:0] o_stored_place;
    logic o_redraw, o_redraw_buffer, o_sample_buffer;

    // predictor copy of the cache
    int unsigned chain_head [BUCKET_COUNT];
    int unsigned chain_next [ENTRY_COUNT];
    int unsigned spare_head;
    logic [KEY_W-1:0] slot_key [ENTRY_COUNT];
    logic [ACT_W-1:0] slot_act [ENTRY_COUNT];
    logic [FRM_W-1:0] slot_frame [ENTRY_COUNT];
    logic [PLC_W-1:0] slot_place [ENTRY_COUNT];
    bit front_first;

    t_result   results_due [$];
    t_stim_row directed [$];
    logic [KEY_W-1:0] pool_key [POOL_SIZE];
    logic [ACT_W-1:0] pool_act [POOL_SIZE];
    int errors = 0;
    int words_seen = 0;
    int burst_left = 0;

    chained_hash_cache_with_free_list_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_op           (i_op),
        .i_key_handle   (i_key_handle),
        .i_action       (i_action),
        .i_frame        (i_frame),
        .i_place_ok     (i_place_ok),
        .i_place_handle (i_place_handle),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_inserted     (o_inserted),
        .o_table_full   (o_table_full),
        .o_entry_index  (o_entry_index),
        .o_stored_place (o_stored_place),
        .o_redraw       (o_redraw),
        .o_redraw_buffer(o_redraw_buffer),
        .o_sample_buffer(o_sample_buffer)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_result cache_access(t_op op, logic [KEY_W-1:0] key,
                                             logic [ACT_W-1:0] act, logic [FRM_W-1:0] frame,
                                             logic ok, logic [PLC_W-1:0] place);
        t_result r;
        logic [KEY_W-1:0] mixed;
        int unsigned bkt, cur, found, fresh;
        r = '0;
        mixed = key ^ (32'(act) * 32'(HASH_MUL));
        bkt = mixed % BUCKET_COUNT;
        cur = chain_head[bkt];
        found = ENTRY_COUNT;
        for (int steps = 0; steps < ENTRY_COUNT; steps++) begin
            if (cur >= ENTRY_COUNT) break;
            if (slot_key[cur] == key && slot_act[cur] == act) begin
                found = cur;
                break;
            end
            cur = chain_next[cur];
        end
        if (found != ENTRY_COUNT) begin
            r.hit = 1'b1;
            r.entry_index = t_oidx'(found);
            r.stored_place = slot_place[found];
            if (op == OP_DRAW && slot_frame[found] != frame) begin
                r.redraw = 1'b1;
                r.redraw_buffer = !front_first;
                front_first = !front_first;
                slot_frame[found] = frame;
            end
        end else if (op == OP_LOAD && ok) begin
            fresh = spare_head;
            if (fresh >= ENTRY_COUNT) begin
                r.table_full = 1'b1;
            end else begin
                spare_head = chain_next[fresh];
                slot_key[fresh] = key;
                slot_act[fresh] = act;
                slot_frame[fresh] = '0;
                slot_place[fresh] = place;
                chain_next[fresh] = chain_head[bkt];
                chain_head[bkt] = fresh;
                r.inserted = 1'b1;
                r.entry_index = t_oidx'(fresh);
                r.stored_place = place;
            end
        end
        r.sample_buffer = !front_first;
        return r;
    endfunction

    function automatic t_stim_row req_word(t_op op, logic [KEY_W-1:0] key,
                                           logic [ACT_W-1:0] act, logic [FRM_W-1:0] frame,
                                           logic ok, logic [PLC_W-1:0] place);
        t_stim_row w;
        w.op = op;
        w.key = key;
        w.act = act;
        w.frame = frame;
        w.ok = ok;
        w.place = place;
        w.known = 1'b0;
        w.want = '0;
        return w;
    endfunction

    function automatic t_stim_row with_result(t_stim_row w, logic hit, logic ins, logic full,
                                              t_oidx idx, logic [PLC_W-1:0] stored,
                                              logic rd, logic rbuf, logic sbuf);
        w.known = 1'b1;
        w.want.hit = hit;
        w.want.inserted = ins;
        w.want.table_full = full;
        w.want.entry_index = idx;
        w.want.stored_place = stored;
        w.want.redraw = rd;
        w.want.redraw_buffer = rbuf;
        w.want.sample_buffer = sbuf;
        return w;
    endfunction

    // mostly back to back, some short gaps, a few long ones, and gapless bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 50);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic issue_word(t_stim_row w);
        int gap;
        t_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= w.op;
        i_key_handle <= w.key;
        i_action <= w.act;
        i_frame <= w.frame;
        i_place_ok <= w.ok;
        i_place_handle <= w.place;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = cache_access(w.op, w.key, w.act, w.frame, w.ok, w.place);
        results_due.push_back(w.known ? w.want : predicted);
    endtask

    task automatic report(string what, t_result want, t_result got);
        errors++;
        if (errors <= 10) begin
            $display("word %0d %s: expected hit %0d ins %0d full %0d idx %0d place %h rd %0d/%0d sb %0d",
                     words_seen, what, want.hit, want.inserted, want.table_full,
                     want.entry_index, want.stored_place, want.redraw, want.redraw_buffer,
                     want.sample_buffer);
            $display("    got hit %0d ins %0d full %0d idx %0d place %h rd %0d/%0d sb %0d",
                     got.hit, got.inserted, got.table_full, got.entry_index,
                     got.stored_place, got.redraw, got.redraw_buffer, got.sample_buffer);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got, want;
        if (i_rst_n && o_valid === 1'b1) begin
            got.hit = o_hit;
            got.inserted = o_inserted;
            got.table_full = o_table_full;
            got.entry_index = o_entry_index;
            got.stored_place = o_stored_place;
            got.redraw = o_redraw;
            got.redraw_buffer = o_redraw_buffer;
            got.sample_buffer = o_sample_buffer;
            if (results_due.size() == 0) begin
                report("unexpected", '0, got);
            end else begin
                want = results_due.pop_front();
                if (got !== want) report("mismatch", want, got);
            end
            words_seen++;
        end
    end

    initial begin
        #50_000_000;
        $display("chained_hash_cache_with_free_list_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_stim_row w;
        int r, p;
        for (int i = 0; i < BUCKET_COUNT; i++) chain_head[i] = ENTRY_COUNT;
        for (int i = 0; i < ENTRY_COUNT; i++) chain_next[i] = i + 1;
        spare_head = 0;
        front_first = 1'b1;

        // a quarter of the pool shares buckets 0 to 2 so chains grow long
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 24) begin
                pool_act[i] = '0;
                pool_key[i] = 32'd101 * $urandom_range(0, 40_000_000) + 32'(i % 3);
            end else begin
                pool_act[i] = ACT_W'($urandom_range(0, 65535));
                pool_key[i] = $urandom;
            end
        end

        // draw miss, failed placer, insert, load hit, frame changes both ways
        directed.push_back(with_result(req_word(OP_DRAW, 32'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                                       1'b0, 1'b0, 1'b0, 6'd0, 16'h0, 1'b0, 1'b0, 1'b0));
        directed.push_back(with_result(req_word(OP_LOAD, 32'h0, 16'h0, 16'hffff, 1'b0, 16'hffff),
                                       1'b0, 1'b0, 1'b0, 6'd0, 16'h0, 1'b0, 1'b0, 1'b0));
        directed.push_back(with_result(req_word(OP_LOAD, 32'h0, 16'h0, 16'h0, 1'b1, 16'h1234),
                                       1'b0, 1'b1, 1'b0, 6'd0, 16'h1234, 1'b0, 1'b0, 1'b0));
        directed.push_back(with_result(req_word(OP_LOAD, 32'h0, 16'h0, 16'h0, 1'b1, 16'h5555),
                                       1'b1, 1'b0, 1'b0, 6'd0, 16'h1234, 1'b0, 1'b0, 1'b0));
        directed.push_back(with_result(req_word(OP_DRAW, 32'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                                       1'b1, 1'b0, 1'b0, 6'd0, 16'h1234, 1'b0, 1'b0, 1'b0));
        directed.push_back(with_result(req_word(OP_DRAW, 32'h0, 16'h0, 16'hffff, 1'b0, 16'h0),
                                       1'b1, 1'b0, 1'b0, 6'd0, 16'h1234, 1'b1, 1'b0, 1'b1));
        directed.push_back(with_result(req_word(OP_DRAW, 32'h0, 16'h0, 16'hffff, 1'b1, 16'h0),
                                       1'b1, 1'b0, 1'b0, 6'd0, 16'h1234, 1'b0, 1'b0, 1'b1));
        directed.push_back(with_result(req_word(OP_DRAW, 32'h0, 16'h0, 16'h0, 1'b0, 16'h0),
                                       1'b1, 1'b0, 1'b0, 6'd0, 16'h1234, 1'b1, 1'b1, 1'b0));
        directed.push_back(with_result(req_word(OP_LOAD, 32'hffffffff, 16'hffff, 16'h0, 1'b1,
                                                16'hffff),
                                       1'b0, 1'b1, 1'b0, 6'd1, 16'hffff, 1'b0, 1'b0, 1'b0));
        // chain walks in bucket 0 and further misses
        directed.push_back(req_word(OP_DRAW, 32'hffffffff, 16'hffff, 16'h8000, 1'b0, 16'h0));
        directed.push_back(req_word(OP_LOAD, 32'd101, 16'h0, 16'h0, 1'b1, 16'h0101));
        directed.push_back(req_word(OP_LOAD, 32'd202, 16'h0, 16'h0, 1'b1, 16'h0202));
        directed.push_back(req_word(OP_DRAW, 32'h0, 16'h0, 16'h0007, 1'b0, 16'h0));
        directed.push_back(req_word(OP_DRAW, 32'd303, 16'h0, 16'h0001, 1'b0, 16'h0));
        directed.push_back(req_word(OP_LOAD, 32'h0, 16'h0001, 16'h0, 1'b1, 16'haaaa));
        directed.push_back(req_word(OP_DRAW, 32'h1, 16'h0, 16'h0, 1'b0, 16'h0));
        directed.push_back(req_word(OP_LOAD, 32'hffffffff, 16'h0, 16'h0, 1'b0, 16'h0));
        directed.push_back(req_word(OP_LOAD, 32'h80000000, 16'h8000, 16'h0, 1'b1, 16'h8000));
        directed.push_back(req_word(OP_DRAW, 32'd202, 16'h0, 16'h0, 1'b0, 16'h0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) issue_word(directed[i]);

        // random words: mostly pooled keys, so the table fills and stays full
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_SIZE - 1);
            w = req_word(r < 45 ? OP_LOAD : OP_DRAW, pool_key[p], pool_act[p],
                         FRM_W'($urandom_range(0, 3)), $urandom_range(0, 99) < 85,
                         PLC_W'($urandom_range(0, 65535)));
            if ($urandom_range(0, 99) < 15) begin
                w.key = $urandom;
                w.act = ACT_W'($urandom_range(0, 65535));
            end
            if ($urandom_range(0, 99) < 20) w.frame = FRM_W'($urandom_range(0, 65535));
            issue_word(w);
        end
        start <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("chained_hash_cache_with_free_list_top: match");
        end else begin
            $display("chained_hash_cache_with_free_list_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/chc_pkg.sv
src/chc_front.sv
src/chc_queue.sv
src/chc_back.sv
src/chained_hash_cache_with_free_list_top.sv
test/tb_top.sv
